### hw/rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared widths, result status codes and the command and status bundles
// that join the interpolation controller to its datapath.
// ----------------------------------------------------------------------------
package tli_pkg;

   localparam int WORD_W     = 32;
   localparam int STAT_W     = 3;
   localparam int REQ_DATA_W = 3 * WORD_W;
   localparam int CNT_W      = $clog2(WORD_W);

   localparam logic [STAT_W-1:0] STAT_INTERP = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EXACT  = 3'd1;
   localparam logic [STAT_W-1:0] STAT_ABOVE  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BELOW  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd4;

   typedef struct packed {
      logic accept;
      logic snap;
      logic prep;
      logic mul;
      logic div_step;
      logic fin;
   } tli_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } tli_stat_type;

endpackage

### hw/rtl/tli_ctrl.sv
// ----------------------------------------------------------------------------
// tli_ctrl
// Sequencer: tracks points, then steps the datapath through bracket
// preparation, multiply and bit-serial divide when needed, and result hand-off.
// ----------------------------------------------------------------------------
module tli_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  tli_pkg::tli_stat_type stat,
   output tli_pkg::tli_cmd_type  cmd
);
   import tli_pkg::*;

   localparam logic [2:0] S_TRACK = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_TRACK);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.accept   = accept;
      cmd.snap     = accept && req_tlast;
      case (state_ff)
         S_TRACK: begin
            if (accept && req_tlast) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = stat.need_div ? S_MUL : S_FIN;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_TRACK;
            end
         end
         default: begin
            state_in = S_TRACK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_TRACK;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/tli_dp.sv
// ----------------------------------------------------------------------------
// tli_dp
// Datapath: nearest-neighbor tracking, bracket snapshot, difference
// preparation, 32x32 multiply, restoring divider and output register.
// ----------------------------------------------------------------------------
module tli_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tli_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  tli_pkg::tli_cmd_type                cmd,
   output tli_pkg::tli_stat_type               stat,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tli_pkg::WORD_W-1:0]          rsp_tdata,
   output logic [tli_pkg::STAT_W-1:0]          rsp_tuser
);
   import tli_pkg::*;

   logic signed [WORD_W-1:0] q, px, py;

   logic                     bf_ff, af_ff, ef_ff;
   logic signed [WORD_W-1:0] bx_ff, by_ff, ax_ff, ay_ff, ey_ff;
   logic                     bf_in, af_in, ef_in;
   logic signed [WORD_W-1:0] bx_in, by_in, ax_in, ay_in, ey_in;

   logic                     sbf_ff, saf_ff, sef_ff;
   logic signed [WORD_W-1:0] sbx_ff, sby_ff, sax_ff, say_ff, sey_ff, sq_ff;

   logic [WORD_W-1:0]        dx_ff, dq_ff, mag_ff, selv_ff;
   logic                     neg_ff, need_div_ff;
   logic [STAT_W-1:0]        selst_ff;
   logic [WORD_W-1:0]        dx_in, dq_in, mag_in, selv_in;
   logic                     neg_in, need_div_in;
   logic [STAT_W-1:0]        selst_in;
   logic [WORD_W:0]          dx_full, dq_full, up_full, dn_full;

   logic [WORD_W-1:0]        rem_ff, lo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [WORD_W:0]          trial;
   logic                     ge;
   logic [WORD_W:0]          trial_sub;

   logic                     rsp_valid_ff;
   logic [WORD_W-1:0]        rsp_value_ff, res_value;
   logic [STAT_W-1:0]        rsp_status_ff;

   assign q  = req_tdata[WORD_W-1:0];
   assign px = req_tdata[2*WORD_W-1:WORD_W];
   assign py = req_tdata[3*WORD_W-1:2*WORD_W];

   always_comb begin
      bf_in = bf_ff; bx_in = bx_ff; by_in = by_ff;
      af_in = af_ff; ax_in = ax_ff; ay_in = ay_ff;
      ef_in = ef_ff; ey_in = ey_ff;
      if ((px < q) && (!bf_ff || (bx_ff < px))) begin
         bf_in = 1'b1; bx_in = px; by_in = py;
      end else if ((q < px) && (!af_ff || (px < ax_ff))) begin
         af_in = 1'b1; ax_in = px; ay_in = py;
      end else if (px == q) begin
         ef_in = 1'b1; ey_in = py;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bf_ff <= 1'b0;
         af_ff <= 1'b0;
         ef_ff <= 1'b0;
      end else if (cmd.snap) begin
         bf_ff <= 1'b0;
         af_ff <= 1'b0;
         ef_ff <= 1'b0;
      end else if (cmd.accept) begin
         bf_ff <= bf_in;
         af_ff <= af_in;
         ef_ff <= ef_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         bx_ff <= bx_in; by_ff <= by_in;
         ax_ff <= ax_in; ay_ff <= ay_in;
         ey_ff <= ey_in;
      end
      if (cmd.snap) begin
         sbf_ff <= bf_in; sbx_ff <= bx_in; sby_ff <= by_in;
         saf_ff <= af_in; sax_ff <= ax_in; say_ff <= ay_in;
         sef_ff <= ef_in; sey_ff <= ey_in;
         sq_ff  <= q;
      end
   end

   assign dx_full = {sax_ff[WORD_W-1], sax_ff} - {sbx_ff[WORD_W-1], sbx_ff};
   assign dq_full = {sq_ff[WORD_W-1], sq_ff} - {sbx_ff[WORD_W-1], sbx_ff};
   assign up_full = {say_ff[WORD_W-1], say_ff} - {sby_ff[WORD_W-1], sby_ff};
   assign dn_full = {sby_ff[WORD_W-1], sby_ff} - {say_ff[WORD_W-1], say_ff};

   always_comb begin
      need_div_in = 1'b0;
      selv_in     = '0;
      selst_in    = STAT_INTERP;
      if (sef_ff) begin
         selv_in = sey_ff; selst_in = STAT_EXACT;
      end else if (!sbf_ff && saf_ff) begin
         selv_in = say_ff; selst_in = STAT_ABOVE;
      end else if (sbf_ff && !saf_ff) begin
         selv_in = sby_ff; selst_in = STAT_BELOW;
      end else if (!sbf_ff) begin
         selv_in = '0; selst_in = STAT_EMPTY;
      end else if (!(sbx_ff < sax_ff)) begin
         selv_in = sby_ff; selst_in = STAT_INTERP;
      end else begin
         need_div_in = 1'b1;
      end
      dx_in  = dx_full[WORD_W-1:0];
      neg_in = (say_ff < sby_ff);
      mag_in = neg_in ? dn_full[WORD_W-1:0] : up_full[WORD_W-1:0];
      if (!(sbx_ff < sq_ff)) begin
         dq_in = '0;
      end else if (!(sq_ff < sax_ff)) begin
         dq_in = dx_full[WORD_W-1:0];
      end else begin
         dq_in = dq_full[WORD_W-1:0];
      end
   end

   assign stat.need_div = need_div_in;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         dx_ff       <= dx_in;
         dq_ff       <= dq_in;
         mag_ff      <= mag_in;
         neg_ff      <= neg_in;
         selv_ff     <= selv_in;
         selst_ff    <= selst_in;
         need_div_ff <= need_div_in;
      end
   end

   assign trial     = {rem_ff, lo_ff[WORD_W-1]};
   assign ge        = (trial >= {1'b0, dx_ff});
   assign trial_sub = trial - {1'b0, dx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.mul) begin
         cnt_ff <= CNT_W'(WORD_W - 1);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         {rem_ff, lo_ff} <= mag_ff * dq_ff;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
         lo_ff  <= {lo_ff[WORD_W-2:0], ge};
      end
   end

   assign stat.div_last = (cnt_ff == '0);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (need_div_ff) begin
         res_value = neg_ff ? (sby_ff - lo_ff) : (sby_ff + lo_ff);
      end else begin
         res_value = selv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_value_ff  <= res_value;
         rsp_status_ff <= need_div_ff ? STAT_INTERP : selst_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

### hw/rtl/table_linear_interpolation.sv
// ----------------------------------------------------------------------------
// table_linear_interpolation
// Piecewise linear interpolation over a streamed, unsorted table of points.
// ----------------------------------------------------------------------------
// Table points are taken at one word per cycle while the sequencer is tracking; a word
// without tlast leaves it tracking. The word with tlast is followed, when both neighbors
// bracket the query, by prepare, multiply, 32 restoring divider steps and result hand-off,
// and by prepare and hand-off otherwise. Hand-off waits only while the output is held.
// The result stays in an output register, so following points stream while it waits.
// Synchronous active-high reset clears the neighbor flags, the sequencer and the output.
module table_linear_interpolation (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] query_x, [63:32] point_x, [95:64] point_y
   input  logic [tli_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] value
   output logic [tli_pkg::WORD_W-1:0]       rsp_tdata,
   // [2:0] status
   output logic [tli_pkg::STAT_W-1:0]       rsp_tuser
);
   import tli_pkg::*;

   tli_cmd_type  cmd;
   tli_stat_type stat;

   tli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tli_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
